// ===== src/bqsm_pkg.sv =====
`default_nettype none
package bqsm_pkg;

  localparam int OCC_W      = 11;
  localparam int SVC_W      = 16;
  localparam int CAP_W      = 11;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 2'd2;

  localparam logic [SVC_W-1:0] SERVICE_TICKS_RST  = 16'd2;
  localparam logic [CAP_W-1:0] CAPACITY_LIMIT_RST = 11'd1024;

  typedef struct packed {
    logic [SVC_W-1:0] service_ticks;
    logic             limit_enable;
    logic [CAP_W-1:0] capacity_limit;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/bqsm_front.sv =====
`default_nettype none
module bqsm_front #(
  parameter int TIME_WIDTH = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_arrive,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output logic                       q_arrive,
  output logic [TIME_WIDTH-1:0]      q_stamp
);

  logic [TIME_WIDTH-1:0] tick_r, tick_nxt;
  logic                  arr_r   [2];
  logic [TIME_WIDTH-1:0] stamp_r [2];
  logic [1:0]            count_r, count_nxt;
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic                  push, pop;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_arrive = arr_r[rd_ptr_r];
  assign q_stamp  = stamp_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    tick_nxt   = push ? tick_r + TIME_WIDTH'(1) : tick_r;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      tick_r   <= tick_nxt;
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      arr_r[wr_ptr_r]   <= in_arrive;
      stamp_r[wr_ptr_r] <= tick_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/bqsm_back.sv =====
`default_nettype none
module bqsm_back #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int TIME_WIDTH  = 40,
  parameter int STAT_WIDTH  = 48,
  localparam int OUT_RAW_W  = bqsm_pkg::OCC_W + 3 + TIME_WIDTH + 5 * STAT_WIDTH,
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire bqsm_pkg::cfg_t         cfg,
  input  wire logic                   q_valid,
  output logic                        q_ready,
  input  wire logic                   q_arrive,
  input  wire logic [TIME_WIDTH-1:0]  q_stamp,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [OUT_TDATA_W-1:0]      out_data
);

  localparam int IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > bqsm_pkg::CAP_W) ? CW : bqsm_pkg::CAP_W;
  localparam int MW1  = (TIME_WIDTH > STAT_WIDTH) ? TIME_WIDTH : STAT_WIDTH;
  localparam int AW   = ((MW1 > CW) ? MW1 : CW) + 1;
  localparam int SW   = STAT_WIDTH;
  localparam int TW   = TIME_WIDTH;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {{(AW + 1 - SW){1'b0}}, a} + {1'b0, b};
    if (s > {{(AW + 1 - SW){1'b0}}, {SW{1'b1}}}) begin
      return {SW{1'b1}};
    end
    return s[SW-1:0];
  endfunction

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  logic [TW-1:0] stamp_mem [QUEUE_DEPTH];

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt, rd_addr;
  logic [TW-1:0] xmit_r, xmit_nxt;
  logic [SW-1:0] occ_sum_r, occ_sum_nxt, soj_sum_r, soj_sum_nxt;
  logic [SW-1:0] idle_cnt_r, idle_cnt_nxt, arr_cnt_r, arr_cnt_nxt;
  logic [SW-1:0] loss_cnt_r, loss_cnt_nxt;
  logic [TW-1:0] rd_data_r, byp_data_r, head_stamp;
  logic          byp_r;
  logic          out_valid_r, out_valid_nxt;

  logic [bqsm_pkg::OCC_W-1:0] occ_r;
  logic                       departed_r, lost_r, idle_r;
  logic [TW-1:0]              sojourn_r;

  logic          fire, full, push, lost, idle, pop, resched;
  logic [CW-1:0] cnt_a;
  logic [CMPW-1:0] cnt_ext, cap_ext, cnt_n_ext;
  logic [TW-1:0] sojourn;
  logic [TW-1:0] svc;

  assign q_ready    = !out_valid_r || out_ready;
  assign fire       = q_valid && q_ready;
  assign head_stamp = byp_r ? byp_data_r : rd_data_r;

  always_comb begin
    cnt_ext  = CMPW'(cnt_r);
    cap_ext  = CMPW'(cfg.capacity_limit);
    full     = (cnt_r >= CW'(QUEUE_DEPTH)) || (cfg.limit_enable && (cnt_ext >= cap_ext));
    push     = q_arrive && !full;
    lost     = q_arrive && full;
    cnt_a    = cnt_r + CW'(push);
    idle     = (cnt_a == '0);
    pop      = (q_stamp == xmit_r) && (cnt_r != '0);
    sojourn  = pop ? q_stamp - head_stamp : '0;
    svc      = (cfg.service_ticks == '0) ? TW'(1) : TW'(cfg.service_ticks);
    cnt_nxt  = cnt_a - CW'(pop);
    resched  = (cnt_nxt != '0) && (q_stamp >= xmit_r);
    cnt_n_ext = CMPW'(cnt_nxt);
    rd_addr  = (fire && pop) ? next_idx(head_r) : head_r;
    head_nxt = rd_addr;
    tail_nxt = (fire && push) ? next_idx(tail_r) : tail_r;
    xmit_nxt = resched ? q_stamp + svc : xmit_r;
    occ_sum_nxt  = sat_add(occ_sum_r, AW'(cnt_r));
    soj_sum_nxt  = pop ? sat_add(soj_sum_r, AW'(sojourn)) : soj_sum_r;
    idle_cnt_nxt = idle ? sat_add(idle_cnt_r, AW'(1)) : idle_cnt_r;
    arr_cnt_nxt  = q_arrive ? sat_add(arr_cnt_r, AW'(1)) : arr_cnt_r;
    loss_cnt_nxt = lost ? sat_add(loss_cnt_r, AW'(1)) : loss_cnt_r;
    out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      xmit_r      <= '0;
      occ_sum_r   <= '0;
      soj_sum_r   <= '0;
      idle_cnt_r  <= '0;
      arr_cnt_r   <= '0;
      loss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      if (fire) begin
        cnt_r      <= cnt_nxt;
        xmit_r     <= xmit_nxt;
        occ_sum_r  <= occ_sum_nxt;
        soj_sum_r  <= soj_sum_nxt;
        idle_cnt_r <= idle_cnt_nxt;
        arr_cnt_r  <= arr_cnt_nxt;
        loss_cnt_r <= loss_cnt_nxt;
      end
    end
  end

  // head stamp prefetch, bypass when the write lands on the next head
  always_ff @(posedge clk) begin
    if (fire && push) begin
      stamp_mem[tail_r] <= q_stamp;
    end
    rd_data_r  <= stamp_mem[rd_addr];
    byp_r      <= fire && push && (tail_r == rd_addr);
    byp_data_r <= q_stamp;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      occ_r      <= cnt_n_ext[bqsm_pkg::OCC_W-1:0];
      departed_r <= pop;
      sojourn_r  <= sojourn;
      lost_r     <= lost;
      idle_r     <= idle;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = OUT_TDATA_W'({loss_cnt_r, arr_cnt_r, idle_cnt_r, soj_sum_r, occ_sum_r,
                                   idle_r, lost_r, sojourn_r, departed_r, occ_r});

endmodule
`default_nettype wire

// ===== src/bounded_queue_service_monitor_top.sv =====
// bounded queue service monitor
// each input beat is one time tick; in_tdata bit 0 says a packet arrives
// in that tick. every input beat yields exactly one output beat with the
// queue occupancy, departure and loss flags, the sojourn of a departing
// packet and five saturating statistics
// each tick passes the front tick queue and then the output register
// throughput: one tick per cycle; the tick queue between the stamping
// front and the service back, plus the output register, let both sides
// run without bubbles, and the head stamp is prefetched from the stamp ram
// so a departure in every cycle is served from its registered read port
// when out_tready is low the output register holds its beat, the two-entry
// tick queue takes at most two more beats and then in_tready drops
// reset (rst_n low, synchronous) empties the queue, zeroes tick time,
// schedule and statistics and restores the register defaults; the stamp
// ram needs no clearing pass
// configuration writes are taken at any cycle and should only be made
// while no ticks are in flight
`default_nettype none
module bounded_queue_service_monitor_top #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int TIME_WIDTH  = 40,
  parameter int STAT_WIDTH  = 48,
  localparam int OUT_RAW_W  = bqsm_pkg::OCC_W + 3 + TIME_WIDTH + 5 * STAT_WIDTH,
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // arrive
  input  wire logic [bqsm_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // occupancy, departed, sojourn_ticks, lost, idle, occupancy_sum,
  // sojourn_sum, idle_count, arrival_count, loss_count
  output logic [OUT_TDATA_W-1:0]                 out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [bqsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bqsm_pkg::CFG_W-1:0]        cfg_wdata
);

  bqsm_pkg::cfg_t cfg_r, cfg_nxt;

  logic                  q_valid, q_ready, q_arrive;
  logic [TIME_WIDTH-1:0] q_stamp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        bqsm_pkg::REG_SERVICE_TICKS:  cfg_nxt.service_ticks  = cfg_wdata;
        bqsm_pkg::REG_LIMIT_ENABLE:   cfg_nxt.limit_enable   = cfg_wdata[0];
        bqsm_pkg::REG_CAPACITY_LIMIT: cfg_nxt.capacity_limit = cfg_wdata[bqsm_pkg::CAP_W-1:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.service_ticks  <= bqsm_pkg::SERVICE_TICKS_RST;
      cfg_r.limit_enable   <= 1'b0;
      cfg_r.capacity_limit <= bqsm_pkg::CAPACITY_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bqsm_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_arrive (in_tdata[0]),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_arrive  (q_arrive),
    .q_stamp   (q_stamp)
  );

  bqsm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH),
    .STAT_WIDTH  (STAT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_arrive  (q_arrive),
    .q_stamp   (q_stamp),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  localparam int DEP_B  = bqsm_pkg::OCC_W;
  localparam int SOJ_LO = DEP_B + 1;
  localparam int IDLE_B = SOJ_LO + TIME_WIDTH + 1;

  a_sojourn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[DEP_B] |-> out_tdata[SOJ_LO +: TIME_WIDTH] == '0)
    else $error("sojourn set without departure");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[IDLE_B] |->
      !out_tdata[DEP_B] && out_tdata[bqsm_pkg::OCC_W-1:0] == '0)
    else $error("idle tick with queued or departing packet");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output stall");

endmodule
`default_nettype wire

// ===== tb/sv/bounded_queue_service_monitor_top_tb.sv =====
`default_nettype none
module bounded_queue_service_monitor_top_tb;
  import bqsm_pkg::*;

  localparam int QDEPTH      = 1024;
  localparam int TIME_W      = 40;
  localparam int STAT_W      = 48;
  localparam int RAW_W       = OCC_W + 3 + TIME_W + 5 * STAT_W;
  localparam int OUT_W       = ((RAW_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_W - RAW_W;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE      = 6;

  // highest field first so the struct maps straight onto out_tdata
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [STAT_W-1:0] loss_count;
    logic [STAT_W-1:0] arrival_count;
    logic [STAT_W-1:0] idle_count;
    logic [STAT_W-1:0] sojourn_sum;
    logic [STAT_W-1:0] occupancy_sum;
    logic              idle;
    logic              lost;
    logic [TIME_W-1:0] sojourn_ticks;
    logic              departed;
    logic [OCC_W-1:0]  occupancy;
  } tick_beat_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  bounded_queue_service_monitor_top #(
    .QUEUE_DEPTH(QDEPTH),
    .TIME_WIDTH (TIME_W),
    .STAT_WIDTH (STAT_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // queue model state
  logic [SVC_W-1:0]  svc_ticks    = SERVICE_TICKS_RST;
  logic              limit_on     = 1'b0;
  logic [CAP_W-1:0]  cap_limit    = CAPACITY_LIMIT_RST;
  logic [TIME_W-1:0] tick_now     = '0;
  logic [TIME_W-1:0] xmit_at      = '0;
  logic [TIME_W-1:0] arrival_stamp [QDEPTH];
  logic [9:0]        head_ptr     = '0;
  logic [9:0]        tail_ptr     = '0;
  logic [OCC_W-1:0]  queued       = '0;
  logic [STAT_W-1:0] occ_total    = '0;
  logic [STAT_W-1:0] sojourn_total = '0;
  logic [STAT_W-1:0] idle_total   = '0;
  logic [STAT_W-1:0] arrive_total = '0;
  logic [STAT_W-1:0] drop_total   = '0;

  tick_beat_t pending_ticks[$];
  int         mismatches  = 0;
  int         beats_seen  = 0;
  int         sender_idle = 0;
  int         recv_stall  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                input logic [STAT_W-1:0] b);
    logic [STAT_W:0] s;
    s = a + b;
    return s[STAT_W] ? '1 : s[STAT_W-1:0];
  endfunction

  function automatic tick_beat_t advance_tick(input logic arrive);
    tick_beat_t       b;
    logic [OCC_W-1:0] start_cnt;
    logic [TIME_W-1:0] svc;
    logic             full;
    b = '0;
    start_cnt = queued;
    svc = (svc_ticks == '0) ? TIME_W'(1) : TIME_W'(svc_ticks);
    occ_total = sat_add(occ_total, STAT_W'(start_cnt));
    if (arrive) begin
      full = (queued >= OCC_W'(QDEPTH)) || (limit_on && queued >= cap_limit);
      arrive_total = sat_add(arrive_total, STAT_W'(1));
      if (full) begin
        b.lost = 1'b1;
        drop_total = sat_add(drop_total, STAT_W'(1));
      end else begin
        arrival_stamp[tail_ptr] = tick_now;
        tail_ptr = tail_ptr + 10'd1;
        queued = queued + 1'b1;
      end
    end
    if (queued == '0) begin
      b.idle = 1'b1;
      idle_total = sat_add(idle_total, STAT_W'(1));
    end
    if (tick_now == xmit_at && start_cnt != '0 && queued != '0) begin
      b.sojourn_ticks = tick_now - arrival_stamp[head_ptr];
      b.departed = 1'b1;
      head_ptr = head_ptr + 10'd1;
      queued = queued - 1'b1;
      sojourn_total = sat_add(sojourn_total, STAT_W'(b.sojourn_ticks));
    end
    if (queued != '0 && tick_now >= xmit_at)
      xmit_at = tick_now + svc;
    tick_now = tick_now + 1'b1;
    b.occupancy     = queued;
    b.occupancy_sum = occ_total;
    b.sojourn_sum   = sojourn_total;
    b.idle_count    = idle_total;
    b.arrival_count = arrive_total;
    b.loss_count    = drop_total;
    return b;
  endfunction

  task automatic send_tick(input logic arrive);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[0] = arrive;
    if (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    pending_ticks.push_back(advance_tick(arrive));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_config(input logic [SVC_W-1:0] svc, input logic lim_en,
                              input logic [CAP_W-1:0] cap);
    logic [CFG_W-1:0]     words [3];
    logic [CFG_IDX_W-1:0] regs  [3];
    words[0] = svc;
    words[1] = CFG_W'(lim_en);
    words[2] = CFG_W'(cap);
    regs = '{REG_SERVICE_TICKS, REG_LIMIT_ENABLE, REG_CAPACITY_LIMIT};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= words[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    svc_ticks = svc;
    limit_on  = lim_en;
    cap_limit = cap;
  endtask

  task automatic send_pattern(input logic [31:0] bits, input int count);
    for (int i = 0; i < count; i++)
      send_tick(bits[i]);
  endtask

  task automatic test_default_service();
    sender_idle = 11;
    recv_stall  = 11;
    send_pattern(32'b0_0001_0011, 9);
    wait_drained();
  endtask

  task automatic test_zero_service();
    apply_config(16'd0, 1'b0, 11'd1024);
    send_pattern(32'b001_0111, 7);
    wait_drained();
  endtask

  task automatic test_capacity_edges();
    apply_config(16'd1, 1'b1, 11'd0);
    send_pattern(32'b011, 3);
    wait_drained();
    apply_config(16'd1, 1'b1, 11'd2047);
    send_pattern(32'b011, 3);
    wait_drained();
  endtask

  // fill past the fifo depth before the next departure
  task automatic test_fifo_full();
    sender_idle = 0;
    recv_stall  = 0;
    apply_config(16'd2000, 1'b1, 11'd2047);
    for (int i = 0; i < QDEPTH + 6; i++)
      send_tick(1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [SVC_W-1:0] svc, input logic lim_en,
                                     input logic [CAP_W-1:0] cap, input int arrive_pct,
                                     input int count);
    apply_config(svc, lim_en, cap);
    sender_idle = idle_pct;
    recv_stall  = stall_pct;
    for (int i = 0; i < count; i++)
      send_tick($urandom_range(99) < arrive_pct);
    wait_drained();
  endtask

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall);

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("beat %0d: %s expected %0h actual %0h", beats_seen, what, want, got);
  endtask

  always @(posedge clk) begin : check_beats
    tick_beat_t got;
    tick_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = tick_beat_t'(out_tdata);
      if (pending_ticks.size() == 0) begin
        report("unexpected beat, occupancy", 64'd0, 64'(got.occupancy));
      end else begin
        want = pending_ticks.pop_front();
        if (got.occupancy !== want.occupancy)
          report("occupancy", 64'(want.occupancy), 64'(got.occupancy));
        if (got.departed !== want.departed)
          report("departed", 64'(want.departed), 64'(got.departed));
        if (got.sojourn_ticks !== want.sojourn_ticks)
          report("sojourn_ticks", 64'(want.sojourn_ticks), 64'(got.sojourn_ticks));
        if (got.lost !== want.lost)
          report("lost", 64'(want.lost), 64'(got.lost));
        if (got.idle !== want.idle)
          report("idle", 64'(want.idle), 64'(got.idle));
        if (got.occupancy_sum !== want.occupancy_sum)
          report("occupancy_sum", 64'(want.occupancy_sum), 64'(got.occupancy_sum));
        if (got.sojourn_sum !== want.sojourn_sum)
          report("sojourn_sum", 64'(want.sojourn_sum), 64'(got.sojourn_sum));
        if (got.idle_count !== want.idle_count)
          report("idle_count", 64'(want.idle_count), 64'(got.idle_count));
        if (got.arrival_count !== want.arrival_count)
          report("arrival_count", 64'(want.arrival_count), 64'(got.arrival_count));
        if (got.loss_count !== want.loss_count)
          report("loss_count", 64'(want.loss_count), 64'(got.loss_count));
      end
      beats_seen++;
    end
  end

  // stall watchdog: no beat moving on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_service();
    test_zero_service();
    test_capacity_edges();
    test_random_traffic(0, 0, 16'd1, 1'b0, 11'd1024, 50, 36);
    test_random_traffic(75, 0, 16'd3, 1'b1, 11'd4, 45, 36);
    test_random_traffic(0, 75, 16'd0, 1'b1, 11'd1, 70, 36);
    test_random_traffic(11, 11, 16'd2, 1'b1, 11'd2047, 55, 36);
    test_random_traffic(0, 0, 16'd65535, 1'b0, 11'd0, 20, 36);
    test_fifo_full();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_ticks.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
